>>> rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

  // Operations that the controller asks of the datapath, one per cycle.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_UP_READ,
    OP_UP_STEP,
    OP_RD_TOP,
    OP_RD_LAST,
    OP_TAKE_LAST,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_DN_STEP,
    OP_PUT,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_t;

  typedef struct packed {
    logic rm_mode;
    logic full;
    logic empty;
    logic at_root;
    logic up_move;
    logic no_left;
    logic dn_move;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/mhpq_dp.sv
`timescale 1ns / 1ps

module mhpq_dp #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned CntW     = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhpq_pkg::ctrl_t     ctrl_i,
  output mhpq_pkg::stat_t     stat_o,
  input  logic                in_fire_i,
  input  logic                mode_i,
  input  logic signed [31:0]  new_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ok_o,
  output logic signed [31:0]  top_value_o,
  output logic [CntW-1:0]     entry_count_o,
  output logic                is_empty_o,
  output logic                is_full_o
);

  // Positions are one-based; entry zero of the store is never used.
  logic signed [31:0] heap_mem_q [CAPACITY + 1];
  logic signed [31:0] rdata_q;

  logic [CntW-1:0]    cnt_q;
  logic               out_valid_q;
  logic               mode_q;
  logic signed [31:0] val_q;
  logic [CntW-1:0]    pos_q;
  logic signed [31:0] top_q;
  logic               ok_q;
  logic signed [31:0] cand_q;
  logic [CntW-1:0]    cand_pos_q;
  logic               cand_mv_q;

  logic               ok_out_q;
  logic signed [31:0] top_out_q;
  logic [CntW-1:0]    cnt_out_q;

  logic [CntW:0]      left;
  logic [CntW:0]      right;
  logic               has_right;
  logic               right_better;
  logic signed [31:0] best_val;
  logic [CntW-1:0]    best_pos;
  logic               dn_move;
  logic               up_move;
  logic               out_busy;
  logic               emit_go;

  logic               wen;
  logic [CntW-1:0]    waddr;
  logic signed [31:0] wdata;
  logic [CntW-1:0]    raddr;

  assign left         = {pos_q, 1'b0};
  assign right        = {pos_q, 1'b1};
  assign has_right    = right <= {1'b0, cnt_q};
  assign right_better = has_right && (rdata_q > cand_q);
  assign best_val     = right_better ? rdata_q : cand_q;
  assign best_pos     = right_better ? right[CntW-1:0] : cand_pos_q;
  assign dn_move      = right_better || cand_mv_q;
  assign up_move      = val_q > rdata_q;
  assign out_busy     = out_valid_q && !out_ready_i;
  assign emit_go      = (ctrl_i.op == mhpq_pkg::OP_EMIT) && !out_busy;

  assign stat_o.rm_mode  = mode_q;
  assign stat_o.full     = cnt_q == CntW'(CAPACITY);
  assign stat_o.empty    = cnt_q == '0;
  assign stat_o.at_root  = pos_q == CntW'(1);
  assign stat_o.up_move  = up_move;
  assign stat_o.no_left  = left > {1'b0, cnt_q};
  assign stat_o.dn_move  = dn_move;
  assign stat_o.out_busy = out_busy;

  always_comb begin
    raddr = '0;
    wen   = 1'b0;
    waddr = pos_q;
    wdata = val_q;
    case (ctrl_i.op)
      mhpq_pkg::OP_UP_READ: raddr = pos_q >> 1;
      mhpq_pkg::OP_UP_STEP: begin
        wen   = up_move;
        wdata = rdata_q;
      end
      mhpq_pkg::OP_RD_TOP:   raddr = CntW'(1);
      mhpq_pkg::OP_RD_LAST:  raddr = cnt_q;
      mhpq_pkg::OP_RD_LEFT:  raddr = left[CntW-1:0];
      mhpq_pkg::OP_RD_RIGHT: raddr = right[CntW-1:0];
      mhpq_pkg::OP_DN_STEP: begin
        wen   = dn_move;
        wdata = best_val;
      end
      mhpq_pkg::OP_PUT: wen = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      heap_mem_q[waddr] <= wdata;
    end
    rdata_q <= heap_mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == mhpq_pkg::OP_RD_LAST) begin
        cnt_q <= cnt_q - CntW'(1);
      end else if (ctrl_i.op == mhpq_pkg::OP_PUT && !mode_q) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      mhpq_pkg::OP_LOAD: begin
        if (in_fire_i) begin
          mode_q <= mode_i;
          val_q  <= new_value_i;
          pos_q  <= cnt_q + CntW'(1);
          top_q  <= '0;
          ok_q   <= 1'b0;
        end
      end
      mhpq_pkg::OP_UP_STEP: begin
        if (up_move) begin
          pos_q <= pos_q >> 1;
        end
      end
      mhpq_pkg::OP_RD_LAST: begin
        top_q <= rdata_q;
        pos_q <= CntW'(1);
      end
      mhpq_pkg::OP_TAKE_LAST: val_q <= rdata_q;
      mhpq_pkg::OP_RD_RIGHT: begin
        if (rdata_q > val_q) begin
          cand_q     <= rdata_q;
          cand_pos_q <= left[CntW-1:0];
          cand_mv_q  <= 1'b1;
        end else begin
          cand_q     <= val_q;
          cand_pos_q <= pos_q;
          cand_mv_q  <= 1'b0;
        end
      end
      mhpq_pkg::OP_DN_STEP: begin
        if (dn_move) begin
          pos_q <= best_pos;
        end
      end
      mhpq_pkg::OP_PUT: ok_q <= 1'b1;
      mhpq_pkg::OP_EMIT: begin
        if (!out_busy) begin
          ok_out_q  <= ok_q;
          top_out_q <= top_q;
          cnt_out_q <= cnt_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_out_q;
  assign top_value_o   = top_out_q;
  assign entry_count_o = cnt_out_q;
  assign is_empty_o    = cnt_out_q == '0;
  assign is_full_o     = cnt_out_q == CntW'(CAPACITY);

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_emit_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> out_valid_q)
    else $error("result not presented after emit");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == mhpq_pkg::OP_PUT && !mode_q) |=> cnt_q == CntW'($past(cnt_q) + 1'b1))
    else $error("insert did not add one entry");

  a_pos_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == mhpq_pkg::OP_PUT || ctrl_i.op == mhpq_pkg::OP_UP_STEP ||
     ctrl_i.op == mhpq_pkg::OP_DN_STEP) |-> pos_q != '0)
    else $error("sift position left the heap");

endmodule

>>> rtl/mhpq_ctrl.sv
`timescale 1ns / 1ps

module mhpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mhpq_pkg::stat_t stat_i,
  output mhpq_pkg::ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_RD_TOP,
    ST_RD_LAST,
    ST_TAKE_LAST,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_PUT,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  mhpq_pkg::ctrl_t ctrl_q;
  logic            rdy_q;

  // Each state has one datapath operation; it is registered with the state.
  function automatic mhpq_pkg::dp_op_e op_of(state_e s);
    mhpq_pkg::dp_op_e op;
    case (s)
      ST_IDLE:      op = mhpq_pkg::OP_LOAD;
      ST_UP_CHK:    op = mhpq_pkg::OP_UP_READ;
      ST_UP_CMP:    op = mhpq_pkg::OP_UP_STEP;
      ST_RD_TOP:    op = mhpq_pkg::OP_RD_TOP;
      ST_RD_LAST:   op = mhpq_pkg::OP_RD_LAST;
      ST_TAKE_LAST: op = mhpq_pkg::OP_TAKE_LAST;
      ST_DN_L:      op = mhpq_pkg::OP_RD_LEFT;
      ST_DN_R:      op = mhpq_pkg::OP_RD_RIGHT;
      ST_DN_CMP:    op = mhpq_pkg::OP_DN_STEP;
      ST_PUT:       op = mhpq_pkg::OP_PUT;
      ST_DONE:      op = mhpq_pkg::OP_EMIT;
      default:      op = mhpq_pkg::OP_NOP;
    endcase
    return op;
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && rdy_q) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.rm_mode) begin
          state_d = stat_i.empty ? ST_DONE : ST_RD_TOP;
        end else begin
          state_d = stat_i.full ? ST_DONE : ST_UP_CHK;
        end
      end
      ST_UP_CHK:    state_d = stat_i.at_root ? ST_PUT : ST_UP_CMP;
      ST_UP_CMP:    state_d = stat_i.up_move ? ST_UP_CHK : ST_PUT;
      ST_RD_TOP:    state_d = ST_RD_LAST;
      ST_RD_LAST:   state_d = ST_TAKE_LAST;
      ST_TAKE_LAST: state_d = ST_DN_L;
      ST_DN_L:      state_d = stat_i.no_left ? ST_PUT : ST_DN_R;
      ST_DN_R:      state_d = ST_DN_CMP;
      ST_DN_CMP:    state_d = stat_i.dn_move ? ST_DN_L : ST_PUT;
      ST_PUT:       state_d = ST_DONE;
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ctrl_q.op <= mhpq_pkg::OP_LOAD;
      rdy_q     <= 1'b1;
    end else begin
      state_q   <= state_d;
      ctrl_q.op <= op_of(state_d);
      rdy_q     <= state_d == ST_IDLE;
    end
  end

  assign in_ready_o = rdy_q;
  assign ctrl_o     = ctrl_q;

endmodule

>>> rtl/max_heap_priority_queue.sv
`timescale 1ns / 1ps

// Binary max-heap priority queue of signed 32-bit values, up to CAPACITY entries.
// Each request on the input channel carries mode_i (0 insert new_value_i, 1 remove
// the largest value). Each request gives exactly one result on the output channel:
// ok_o, the removed value on top_value_o (zero for inserts and failed removes), and
// the entry count with the empty and full flags as they stand after the request.
// One request is worked on at a time, in a controller that steps a datapath around
// a single-port-read, single-port-write heap memory with registered read data.
// An insert sifts up, one level per pass through the compare states, until it
// stops or reaches the root; a remove reads the top and the last entry, then sinks
// the last entry one level per pass until it rests; a refused request goes straight
// from decode to the result. in_ready_o rises again at the edge that loads the
// result register, so a new request may be taken while the previous result still
// waits for out_ready_i. If the receiver stalls and a second result is finished,
// the block holds in its final state until the result register is free. Reset
// empties the queue at once; the memory needs no clearing since only written
// entries are ever used.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic signed [31:0]                  new_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                ok_o,
  output logic signed [31:0]                  top_value_o,
  output logic [$clog2(CAPACITY + 1)-1:0]     entry_count_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  mhpq_pkg::ctrl_t ctrl;
  mhpq_pkg::stat_t stat;
  logic            in_fire;

  // A request is taken only while the controller is idle.
  assign in_fire = in_valid_i && in_ready_o;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // The datapath holds the heap memory, the entry count, the sift registers
  // and the result register that parts the two channels.
  mhpq_dp #(
    .CAPACITY (CAPACITY),
    .CntW     (CntW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .in_fire_i     (in_fire),
    .mode_i        (mode_i),
    .new_value_i   (new_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .top_value_o   (top_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

endmodule
